// File: hdl/nearest_palette_color_search_unit_macros.svh
// assertion macros for the nearest palette colour search unit
// no dependencies; define NO_ASSERTIONS to leave the checks out
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NPCS_ASSERT_IMM(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NPCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPCS_ASSERT_IMM(label, clk, rst_n, ante, cons)
`define NPCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/npcs_pkg.sv
// shared constants, types and the tv colour rom for the palette search unit
// no dependencies
`default_nettype none
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 3 * BYTE_W;
  localparam int IDX_W   = 8;
  localparam int SQ_W    = 2 * BYTE_W;
  localparam int ERR_W   = SQ_W + 3;
  localparam int LANES   = 4;
  localparam logic [ERR_W-1:0] START_ERROR = ERR_W'(100000);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_COLOR = 2'd1,
    OP_TV    = 2'd2
  } op_t;

  typedef struct packed {
    logic               en;
    logic [PAL_AW-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_req_t;

  typedef struct packed {
    logic               vld;
    logic [PAL_AW-1:0]  idx;
    logic [COLOR_W-1:0] color;
  } pal_rd_t;

  // colour packed as {blue, green, red}: red is byte 1, blue lands in byte 3
  function automatic logic [COLOR_W-1:0] tv_color(input logic [BYTE_W-1:0] code);
    logic [COLOR_W-1:0] c;
    case (code)
      8'h02: c = {8'd10, 8'd9, 8'd10};
      8'h03: c = {8'd52, 8'd52, 8'd52};
      8'h04: c = {8'd114, 8'd114, 8'd114};
      8'h05: c = {8'd177, 8'd177, 8'd177};
      8'h06: c = {8'd240, 8'd245, 8'd250};
      8'h07: c = {8'd255, 8'd255, 8'd255};
      8'h08: c = {8'd114, 8'd168, 8'd0};
      8'h0A: c = {8'd10, 8'd0, 8'd125};
      8'h0B: c = {8'd52, 8'd32, 8'd177};
      8'h0C: c = {8'd114, 8'd88, 8'd240};
      8'h0D: c = {8'd177, 8'd153, 8'd255};
      8'h0E: c = {8'd229, 8'd214, 8'd255};
      8'h18: c = {8'd188, 8'd136, 8'd0};
      8'h1A: c = {8'd0, 8'd0, 8'd127};
      8'h1B: c = {8'd32, 8'd46, 8'd167};
      8'h1C: c = {8'd92, 8'd108, 8'd229};
      8'h1D: c = {8'd146, 8'd172, 8'd255};
      8'h1E: c = {8'd209, 8'd233, 8'd255};
      8'h28: c = {8'd240, 8'd94, 8'd0};
      8'h2A: c = {8'd0, 8'd16, 8'd94};
      8'h2B: c = {8'd10, 8'd62, 8'd146};
      8'h2C: c = {8'd62, 8'd124, 8'd198};
      8'h2D: c = {8'd125, 8'd188, 8'd255};
      8'h2E: c = {8'd188, 8'd250, 8'd255};
      8'h38: c = {8'd255, 8'd58, 8'd0};
      8'h3A: c = {8'd0, 8'd32, 8'd52};
      8'h3B: c = {8'd0, 8'd78, 8'd104};
      8'h3C: c = {8'd52, 8'd138, 8'd159};
      8'h3D: c = {8'd114, 8'd203, 8'd229};
      8'h3E: c = {8'd177, 8'd255, 8'd255};
      8'h48: c = {8'd255, 8'd22, 8'd114};
      8'h4A: c = {8'd0, 8'd42, 8'd10};
      8'h4B: c = {8'd0, 8'd88, 8'd52};
      8'h4C: c = {8'd42, 8'd146, 8'd114};
      8'h4D: c = {8'd104, 8'd214, 8'd177};
      8'h4E: c = {8'd167, 8'd255, 8'd245};
      8'h58: c = {8'd255, 8'd6, 8'd250};
      8'h5A: c = {8'd0, 8'd52, 8'd0};
      8'h5B: c = {8'd0, 8'd94, 8'd10};
      8'h5C: c = {8'd52, 8'd156, 8'd73};
      8'h5D: c = {8'd114, 8'd219, 8'd136};
      8'h5E: c = {8'd177, 8'd255, 8'd198};
      8'h68: c = {8'd241, 8'd6, 8'd255};
      8'h6A: c = {8'd0, 8'd52, 8'd0};
      8'h6B: c = {8'd10, 8'd94, 8'd0};
      8'h6C: c = {8'd62, 8'd156, 8'd32};
      8'h6D: c = {8'd125, 8'd219, 8'd94};
      8'h6E: c = {8'd188, 8'd255, 8'd156};
      8'h78: c = {8'd177, 8'd26, 8'd255};
      8'h7A: c = {8'd0, 8'd42, 8'd0};
      8'h7B: c = {8'd32, 8'd93, 8'd0};
      8'h7C: c = {8'd84, 8'd151, 8'd5};
      8'h7D: c = {8'd146, 8'd218, 8'd62};
      8'h7E: c = {8'd209, 8'd255, 8'd125};
      8'h88: c = {8'd114, 8'd62, 8'd255};
      8'h8A: c = {8'd10, 8'd32, 8'd0};
      8'h8B: c = {8'd52, 8'd78, 8'd0};
      8'h8C: c = {8'd114, 8'd137, 8'd0};
      8'h8D: c = {8'd177, 8'd203, 8'd52};
      8'h8E: c = {8'd240, 8'd255, 8'd114};
      8'h98: c = {8'd42, 8'd99, 8'd255};
      8'h9A: c = {8'd32, 8'd16, 8'd0};
      8'h9B: c = {8'd76, 8'd62, 8'd0};
      8'h9C: c = {8'd136, 8'd125, 8'd10};
      8'h9D: c = {8'd201, 8'd188, 8'd71};
      8'h9E: c = {8'd255, 8'd250, 8'd128};
      8'hA8: c = {8'd0, 8'd136, 8'd255};
      8'hAA: c = {8'd52, 8'd0, 8'd0};
      8'hAB: c = {8'd104, 8'd46, 8'd0};
      8'hAC: c = {8'd156, 8'd110, 8'd32};
      8'hAD: c = {8'd219, 8'd172, 8'd94};
      8'hAE: c = {8'd255, 8'd235, 8'd156};
      8'hB8: c = {8'd0, 8'd177, 8'd250};
      8'hBA: c = {8'd73, 8'd0, 8'd0};
      8'hBB: c = {8'd114, 8'd32, 8'd10};
      8'hBC: c = {8'd167, 8'd94, 8'd73};
      8'hBD: c = {8'd237, 8'd156, 8'd136};
      8'hBE: c = {8'd255, 8'd219, 8'd198};
      8'hC8: c = {8'd0, 8'd210, 8'd116};
      8'hCA: c = {8'd73, 8'd0, 8'd10};
      8'hCB: c = {8'd114, 8'd22, 8'd59};
      8'hCC: c = {8'd177, 8'd78, 8'd114};
      8'hCD: c = {8'd240, 8'd146, 8'd177};
      8'hCE: c = {8'd255, 8'd203, 8'd240};
      8'hD8: c = {8'd0, 8'd229, 8'd0};
      8'hDA: c = {8'd73, 8'd0, 8'd61};
      8'hDB: c = {8'd114, 8'd16, 8'd104};
      8'hDC: c = {8'd167, 8'd73, 8'd168};
      8'hDD: c = {8'd240, 8'd136, 8'd229};
      8'hDE: c = {8'd255, 8'd198, 8'd255};
      8'hE8: c = {8'd0, 8'd229, 8'd0};
      8'hEA: c = {8'd52, 8'd0, 8'd94};
      8'hEB: c = {8'd94, 8'd16, 8'd146};
      8'hEC: c = {8'd156, 8'd73, 8'd198};
      8'hED: c = {8'd219, 8'd136, 8'd255};
      8'hEE: c = {8'd255, 8'd198, 8'd255};
      8'hF8: c = {8'd42, 8'd206, 8'd0};
      8'hFA: c = {8'd32, 8'd0, 8'd119};
      8'hFB: c = {8'd71, 8'd22, 8'd167};
      8'hFC: c = {8'd136, 8'd83, 8'd229};
      8'hFD: c = {8'd198, 8'd145, 8'd255};
      8'hFE: c = {8'd255, 8'd203, 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/npcs_palette.sv
// palette store: one write port, one registered read port, valid bit per entry
// depends on npcs_pkg
`default_nettype none
module npcs_palette (
  input  wire                  clk,
  input  wire                  rst_n,
  input  npcs_pkg::pal_wr_t     wr,
  input  npcs_pkg::pal_rd_req_t rd_req,
  output npcs_pkg::pal_rd_t     rd
);

  logic [npcs_pkg::COLOR_W-1:0]         mem [npcs_pkg::PALETTE_ENTRIES];
  logic [npcs_pkg::PALETTE_ENTRIES-1:0] valid_r;
  logic [npcs_pkg::COLOR_W-1:0]         rdata_r;
  logic                                 rhit_r;
  logic                                 rvld_r;
  logic [npcs_pkg::PAL_AW-1:0]          ridx_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.color;
    end
    rdata_r <= mem[rd_req.addr];
    rhit_r  <= valid_r[rd_req.addr];
    ridx_r  <= rd_req.addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      rvld_r <= rd_req.en;
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
    end
  end

  // never-written entries read as black
  assign rd.vld   = rvld_r;
  assign rd.idx   = ridx_r;
  assign rd.color = rhit_r ? rdata_r : '0;

endmodule
`default_nettype wire

// File: hdl/npcs_lane.sv
// one search lane: weighted squared error against the streamed palette, keeps the best
// depends on npcs_pkg and the assertion macro header
`default_nettype none
`include "nearest_palette_color_search_unit_macros.svh"
module npcs_lane (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           clr,
  input  wire [npcs_pkg::COLOR_W-1:0]   query,
  input  npcs_pkg::pal_rd_t              rd,
  output logic [npcs_pkg::PAL_AW-1:0]   best_idx
);

  localparam int BW = npcs_pkg::BYTE_W;

  logic [BW-1:0]                  d1, d2, d3;
  logic [npcs_pkg::SQ_W-1:0]      sq1_r, sq2_r, sq3_r;
  logic                           s1_vld_r;
  logic [npcs_pkg::PAL_AW-1:0]    s1_idx_r;
  logic [npcs_pkg::ERR_W-1:0]     err;
  logic [npcs_pkg::ERR_W-1:0]     best_err_r, best_err_nxt;
  logic [npcs_pkg::PAL_AW-1:0]    best_idx_r, best_idx_nxt;
  logic                           better;

  function automatic logic [BW-1:0] abs_diff(input logic [BW-1:0] a, input logic [BW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign d1 = abs_diff(query[BW-1:0],      rd.color[BW-1:0]);
  assign d2 = abs_diff(query[2*BW-1:BW],   rd.color[2*BW-1:BW]);
  assign d3 = abs_diff(query[3*BW-1:2*BW], rd.color[3*BW-1:2*BW]);

  always_ff @(posedge clk) begin
    sq1_r    <= npcs_pkg::SQ_W'(d1) * npcs_pkg::SQ_W'(d1);
    sq2_r    <= npcs_pkg::SQ_W'(d2) * npcs_pkg::SQ_W'(d2);
    sq3_r    <= npcs_pkg::SQ_W'(d3) * npcs_pkg::SQ_W'(d3);
    s1_idx_r <= rd.idx;
  end

  // green weighted double
  assign err = npcs_pkg::ERR_W'(sq1_r) + (npcs_pkg::ERR_W'(sq2_r) << 1)
             + npcs_pkg::ERR_W'(sq3_r);
  assign better = s1_vld_r && (err < best_err_r);

  always_comb begin
    best_err_nxt = best_err_r;
    best_idx_nxt = best_idx_r;
    if (clr) begin
      best_err_nxt = npcs_pkg::START_ERROR;
      best_idx_nxt = '0;
    end else if (better) begin
      best_err_nxt = err;
      best_idx_nxt = s1_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      best_err_r <= npcs_pkg::START_ERROR;
      best_idx_r <= '0;
    end else begin
      s1_vld_r   <= rd.vld;
      best_err_r <= best_err_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

  assign best_idx = best_idx_r;

  `NPCS_ASSERT_IMM(a_err_bounded, clk, rst_n, 1'b1, best_err_r <= npcs_pkg::START_ERROR)
  `NPCS_ASSERT_NXT(a_clr_init, clk, rst_n, clr, best_idx_r == '0 && best_err_r == npcs_pkg::START_ERROR)
  `NPCS_ASSERT_NXT(a_take_better, clk, rst_n, !clr && better, best_idx_r == $past(s1_idx_r))
  `NPCS_ASSERT_NXT(a_hold_idle, clk, rst_n, !clr && !s1_vld_r, $stable(best_idx_r))

endmodule
`default_nettype wire

// File: hdl/nearest_palette_color_search_unit.sv
// Nearest palette colour search unit. An op 0 transfer writes one palette entry and busy
// stays low. A colour query or a TV query raises busy while the single palette read port
// streams one entry per cycle to four lanes that each track the lowest weighted error,
// followed by a drain state while the last entries pass through the read and lane registers.
// The result then sits on out_index_a..d with out_strobe high for one cycle; the receiver
// cannot stall, and a new item may be started in that same cycle, so a new query is taken
// only once the previous one has finished. The palette reads as all black after reset
// through per-entry valid bits, with no clearing pass.
`default_nettype none
`include "nearest_palette_color_search_unit_macros.svh"
module nearest_palette_color_search_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  in_op,
  input  wire [7:0]  in_entry_index,
  input  wire [7:0]  in_query_red,
  input  wire [7:0]  in_query_green,
  input  wire [7:0]  in_query_blue,
  input  wire [31:0] in_tv_codes,
  output logic       out_strobe,
  output logic [7:0] out_index_a,
  output logic [7:0] out_index_b,
  output logic [7:0] out_index_c,
  output logic [7:0] out_index_d
);

  localparam int DRAIN_CYCLES = 3;
  localparam int BW = npcs_pkg::BYTE_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [npcs_pkg::CNT_W-1:0]   addr_r, addr_nxt;
  logic [1:0]                   drain_r, drain_nxt;
  npcs_pkg::op_t                op_r;
  logic                         out_strobe_r, out_strobe_nxt;
  logic [npcs_pkg::IDX_W-1:0]   out_idx_r [npcs_pkg::LANES];
  logic [npcs_pkg::COLOR_W-1:0] q_r [npcs_pkg::LANES];
  logic [npcs_pkg::PAL_AW-1:0]  lane_best [npcs_pkg::LANES];
  logic                         accept, is_query, finish;
  logic [npcs_pkg::COLOR_W-1:0] in_color;
  npcs_pkg::pal_wr_t            pal_wr;
  npcs_pkg::pal_rd_req_t        pal_req;
  npcs_pkg::pal_rd_t            pal_rd;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = (in_op == npcs_pkg::OP_COLOR) || (in_op == npcs_pkg::OP_TV);
  assign in_color = {in_query_blue, in_query_green, in_query_red};
  assign finish   = (state_r == ST_DRAIN) && (drain_r == 2'(DRAIN_CYCLES - 1));

  assign pal_wr.en    = accept && (in_op == npcs_pkg::OP_WRITE)
                        && ({1'b0, in_entry_index} < 9'(npcs_pkg::PALETTE_ENTRIES));
  assign pal_wr.addr  = in_entry_index[npcs_pkg::PAL_AW-1:0];
  assign pal_wr.color = in_color;

  assign pal_req.en   = (state_r == ST_SCAN);
  assign pal_req.addr = addr_r[npcs_pkg::PAL_AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    drain_nxt      = drain_r;
    out_strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = ST_SCAN;
          addr_nxt  = '0;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == npcs_pkg::CNT_W'(npcs_pkg::PALETTE_ENTRIES - 1)) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (finish) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      addr_r       <= '0;
      drain_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      drain_r      <= drain_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // query colours per lane; top code byte goes to lane 0
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      op_r <= npcs_pkg::op_t'(in_op);
      for (int i = 0; i < npcs_pkg::LANES; i++) begin
        if (in_op == npcs_pkg::OP_COLOR) begin
          q_r[i] <= in_color;
        end else begin
          q_r[i] <= npcs_pkg::tv_color(in_tv_codes[32-1-BW*i -: BW]);
        end
      end
    end
  end

  npcs_palette u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd_req (pal_req),
    .rd     (pal_rd)
  );

  for (genvar g = 0; g < npcs_pkg::LANES; g++) begin : g_lane
    npcs_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (accept && is_query),
      .query    (q_r[g]),
      .rd       (pal_rd),
      .best_idx (lane_best[g])
    );
  end

  // merge the lanes into the result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_idx_r[0] <= npcs_pkg::IDX_W'(lane_best[0]);
      for (int i = 1; i < npcs_pkg::LANES; i++) begin
        out_idx_r[i] <= (op_r == npcs_pkg::OP_TV) ? npcs_pkg::IDX_W'(lane_best[i]) : '0;
      end
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_index_a = out_idx_r[0];
  assign out_index_b = out_idx_r[1];
  assign out_index_c = out_idx_r[2];
  assign out_index_d = out_idx_r[3];

  `NPCS_ASSERT_NXT(a_query_scans, clk, rst_n, accept && is_query, state_r == ST_SCAN && addr_r == '0)
  `NPCS_ASSERT_IMM(a_strobe_after_drain, clk, rst_n, out_strobe_r, $past(state_r) == ST_DRAIN && state_r == ST_IDLE)
  `NPCS_ASSERT_IMM(a_addr_range, clk, rst_n, state_r == ST_SCAN, addr_r < npcs_pkg::CNT_W'(npcs_pkg::PALETTE_ENTRIES))
  `NPCS_ASSERT_IMM(a_color_zero, clk, rst_n, out_strobe_r && op_r == npcs_pkg::OP_COLOR, out_index_b == '0 && out_index_c == '0 && out_index_d == '0)

endmodule
`default_nettype wire
